// ----- hw/rtl/lir_pkg.sv -----
// Shared types and constants for the linear interpolation resampler.
// No dependencies; every other file of the block imports this package.
package lir_pkg;

    localparam int unsigned TARGET_RATE_DEF = 16000;
    localparam int          SAMPLE_W        = 16;
    localparam int          RATE_W          = 18;
    localparam int          MAX_RESULTS     = 32;
    // quotient bits of the offset-binary interpolation step
    localparam int          QW              = SAMPLE_W + 1;
    // reciprocal divide steps: an estimate step, then a correction step
    localparam int          DIV_STEPS       = 2;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
    localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(1000);
    localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(192000);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int IDX_W   = PADDR_W - 2;
    localparam logic [IDX_W-1:0] REG_SOURCE_RATE = IDX_W'(0);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       stream_last;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       run_last;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_load;
        logic div_step;
        logic emit;
        logic emit_tail;
        logic run_last;
        logic adv;
        logic wrap;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic have;
        logic last;
        logic ph_lt_t;
        logic nxt_lt_t;
        logic nxt_wrap_lt_t;
        logic out_free;
    } t_sts;

endpackage

// ----- hw/rtl/lir_ctrl.sv -----
// Sequencer of the resampler: walks the interpolation and tail loops per input word.
// Depends on lir_pkg for the command and status structs.
module lir_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lir_pkg::t_sts i_sts,
    output lir_pkg::t_cmd o_cmd,
    output logic          o_idle
);
    import lir_pkg::*;

    localparam int CW = $clog2(MAX_RESULTS + 1);
    localparam int SW = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOP, S_DLOAD, S_DIV, S_EMIT, S_TAIL, S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_step, n_step;
    logic          w_room, w_room2;

    assign w_room  = r_cnt < CW'(MAX_RESULTS);
    assign w_room2 = r_cnt < CW'(MAX_RESULTS - 1);
    assign o_idle  = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_LOOP;
                end
            end
            S_LOOP: begin
                if (!i_sts.have) begin
                    n_state = S_TAIL;
                end else if (i_sts.ph_lt_t) begin
                    if (w_room) begin
                        o_cmd.mul = 1'b1;
                        n_state   = S_DLOAD;
                    end else begin
                        // result limit reached: advance phase without output
                        o_cmd.adv = 1'b1;
                    end
                end else begin
                    o_cmd.wrap = 1'b1;
                    n_state    = S_TAIL;
                end
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + SW'(1);
                if (r_step == SW'(DIV_STEPS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.run_last = !(w_room2 && (i_sts.nxt_lt_t ||
                                       (i_sts.last && i_sts.nxt_wrap_lt_t)));
                    o_cmd.adv      = 1'b1;
                    n_cnt          = r_cnt + CW'(1);
                    n_state        = S_LOOP;
                end
            end
            S_TAIL: begin
                if (i_sts.last && i_sts.ph_lt_t && w_room) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_tail = 1'b1;
                        o_cmd.run_last  = !(w_room2 && i_sts.nxt_lt_t);
                        o_cmd.adv       = 1'b1;
                        n_cnt           = r_cnt + CW'(1);
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
        end
    end

endmodule

// ----- hw/rtl/lir_dpath.sv -----
// Datapath of the resampler: stream state, phase, multiplier, reciprocal divide, output register.
// Depends on lir_pkg; driven by lir_ctrl commands.
module lir_dpath #(
    parameter int unsigned TARGET_RATE = lir_pkg::TARGET_RATE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lir_pkg::t_in_word          i_in_data,
    input  logic [lir_pkg::RATE_W-1:0] i_source_rate,
    input  lir_pkg::t_cmd              i_cmd,
    output lir_pkg::t_sts              o_sts,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output lir_pkg::t_out_word         o_out_data
);
    import lir_pkg::*;

    localparam int TW  = $clog2(TARGET_RATE);
    localparam int PW  = $clog2(TARGET_RATE + int'(RATE_MAX));
    localparam int DFW = SAMPLE_W + 1;
    localparam int PRW = DFW + TW + 1;
    localparam int DW  = QW + TW;

    localparam logic [PW-1:0] T_P  = PW'(TARGET_RATE);
    localparam logic [PW:0]   T2_P = (PW + 1)'(2 * TARGET_RATE);
    localparam logic [DW-1:0] T_W  = DW'(TARGET_RATE);
    // 2^DW / T rounded down; the quotient estimate is low by at most one
    localparam logic [QW:0]   T_RCP = (QW + 1)'((longint'(1) << DW) / longint'(TARGET_RATE));
    // offset keeps the dividend positive; quotient comes out in offset binary
    localparam longint        OFS_L = longint'(TARGET_RATE) * (longint'(1) << (QW - 1))
                                      + longint'(TARGET_RATE / 2);
    localparam logic signed [PRW:0] DIV_OFS = (PRW + 1)'(OFS_L);

    logic signed [SAMPLE_W-1:0] r_prev, r_cur;
    logic                       r_have, r_last;
    logic [PW-1:0]              r_phase;
    logic [RATE_W-1:0]          r_s, n_s;
    logic signed [DFW-1:0]      r_diff;
    logic signed [PRW-1:0]      r_prod;
    logic [DW-1:0]              r_num;
    logic [QW-1:0]              r_qe, r_quo;
    logic                       r_ovalid;
    t_out_word                  r_odata;

    logic [PW:0]            w_nxt;
    logic [DW+QW:0]         w_eprod;
    logic [DW-1:0]          w_qt, w_rem;
    logic                   w_fix;
    logic signed [PRW:0]    w_num;
    logic [QW-1:0]          w_qs;
    logic [SAMPLE_W+1:0]    w_val;

    always_comb begin
        if (i_source_rate < RATE_MIN) begin
            n_s = RATE_MIN;
        end else if (i_source_rate > RATE_MAX) begin
            n_s = RATE_MAX;
        end else begin
            n_s = i_source_rate;
        end
    end

    assign w_nxt   = {1'b0, r_phase} + (PW + 1)'(r_s);
    assign w_num   = $signed({r_prod[PRW-1], r_prod}) + DIV_OFS;
    // estimate the quotient, then bump it once if the remainder is still >= T
    assign w_eprod = {{(QW + 1){1'b0}}, r_num} * {{DW{1'b0}}, T_RCP};
    assign w_qt    = {{TW{1'b0}}, r_qe} * T_W;
    assign w_rem   = r_num - w_qt;
    assign w_fix   = (w_rem >= T_W);
    // flip the offset-binary MSB to get the signed correction term
    assign w_qs    = {~r_quo[QW-1], r_quo[QW-2:0]};
    assign w_val   = {{2{r_prev[SAMPLE_W-1]}}, r_prev} + {w_qs[QW-1], w_qs};

    assign o_sts.have          = r_have;
    assign o_sts.last          = r_last;
    assign o_sts.ph_lt_t       = (r_phase < T_P);
    assign o_sts.nxt_lt_t      = (w_nxt < {1'b0, T_P});
    assign o_sts.nxt_wrap_lt_t = (w_nxt < T2_P);
    assign o_sts.out_free      = !r_ovalid || !i_out_stall;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur  <= i_in_data.sample_in;
            r_last <= i_in_data.stream_last;
            r_s    <= n_s;
            r_diff <= $signed({i_in_data.sample_in[SAMPLE_W-1], i_in_data.sample_in})
                    - $signed({r_prev[SAMPLE_W-1], r_prev});
        end
        if (i_cmd.mul) begin
            r_prod <= r_diff * $signed({1'b0, r_phase[TW-1:0]});
        end
        if (i_cmd.div_load) begin
            r_num <= w_num[DW-1:0];
        end
        // first step settles the estimate, second step applies the correction
        if (i_cmd.div_step) begin
            r_qe  <= w_eprod[DW+QW-1:DW];
            r_quo <= r_qe + QW'(w_fix);
        end
        if (i_cmd.emit) begin
            r_odata.sample_out <= i_cmd.emit_tail ? r_cur : $signed(w_val[SAMPLE_W-1:0]);
            r_odata.run_last   <= i_cmd.run_last;
        end
    end

    // stream state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_have   <= 1'b0;
            r_phase  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                if (r_last) begin
                    r_prev  <= '0;
                    r_have  <= 1'b0;
                    r_phase <= '0;
                end else begin
                    r_prev <= r_cur;
                    r_have <= 1'b1;
                end
            end else if (i_cmd.adv) begin
                r_phase <= w_nxt[PW-1:0];
            end else if (i_cmd.wrap) begin
                r_phase <= r_phase - T_P;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/linear_interp_resampler_core.sv -----
// Top level of the linear interpolation resampler: APB register, sequencer and datapath.
// Depends on lir_pkg, lir_ctrl and lir_dpath.
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+---------------------------
//  input    | in        | i_in_valid / o_in_stall   | sample_in, stream_last
//  output   | out       | o_out_valid / i_out_stall | sample_out, run_last
//  config   | in        | psel/penable/pwrite/pready| source_rate at byte addr 0
//
// One input word is handled at a time; o_in_stall is high from acceptance until
// the word's results are all handed to the output register and the stream state
// is committed. Each interpolated result takes a phase check, a dividend load,
// the estimate and correction steps of the reciprocal divide and the emit; tail
// results are emitted directly, and positions past the 32-result limit only
// advance the phase. A stalled output holds its word and the sequencer waits.
// Reset is synchronous and active low; it clears the stream state and restores
// source_rate to 48000.
module linear_interp_resampler_core #(
    parameter int unsigned TARGET_RATE = lir_pkg::TARGET_RATE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  lir_pkg::t_in_word           i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output lir_pkg::t_out_word          o_out_data,
    input  logic                        i_out_stall,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lir_pkg::PADDR_W-1:0] paddr,
    input  logic [lir_pkg::PDATA_W-1:0] pwdata,
    output logic [lir_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import lir_pkg::*;

    logic [RATE_W-1:0] r_source_rate;
    logic [IDX_W-1:0]  w_idx;
    logic              w_idle;
    t_cmd              w_cmd;
    t_sts              w_sts;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:2];

    // config write lands in the access phase; the user must issue writes only while idle (not enforced)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_rate <= RATE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (w_idx == REG_SOURCE_RATE) begin
                r_source_rate <= pwdata[RATE_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == REG_SOURCE_RATE) begin
            prdata = PDATA_W'(r_source_rate);
        end
    end

    // hold the input side off while a word is in flight
    assign o_in_stall = !w_idle;

    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle)
    );

    lir_dpath #(
        .TARGET_RATE (TARGET_RATE)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_source_rate (r_source_rate),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule

// ----- hw/rtl/lir_checker.sv -----
// Port-level checks for the resampler top level, bound to every instance.
// Depends on lir_pkg and linear_interp_resampler_core.
module lir_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  lir_pkg::t_in_word           i_in_data,
    input  logic                        o_in_stall,
    input  logic                        o_out_valid,
    input  lir_pkg::t_out_word          o_out_data,
    input  logic                        i_out_stall,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lir_pkg::PADDR_W-1:0] paddr,
    input  logic [lir_pkg::PDATA_W-1:0] pwdata,
    input  logic [lir_pkg::PDATA_W-1:0] prdata,
    input  logic                        pready
);
    import lir_pkg::*;

    // an accepted word keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted but block not busy next cycle");

    // results appear only while a word is being worked on
    a_no_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && (!o_out_valid || !i_out_stall)) |=> !o_out_valid)
        else $error("new result appeared while idle");

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped under stall");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("output word changed under stall");

endmodule

bind linear_interp_resampler_core lir_checker u_lir_checker (.*);

// ----- bench/lir_stream_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for linear_interp_resampler_core: watches the input, output and APB
// channels, predicts each resampled word and compares. Depends on lir_pkg.
module lir_stream_checker #(
    parameter int unsigned TARGET_RATE = lir_pkg::TARGET_RATE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  lir_pkg::t_in_word           i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  lir_pkg::t_out_word          i_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [lir_pkg::PADDR_W-1:0] paddr,
    input  logic [lir_pkg::PDATA_W-1:0] pwdata,
    output int                          o_pending,
    output int                          o_fails
);
    import lir_pkg::*;

    // shadow copy of the block's register and stream state
    logic [RATE_W-1:0] rate_reg;
    int                prev_sample;
    int unsigned       phase_acc;
    bit                have_prev;

    t_out_word         sample_q[$];
    t_out_word         oldest;
    int                words_seen;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on output word %0d: %s", $realtime, words_seen, msg);
        o_fails++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] blend(input int a, input int b,
                                                        input int unsigned p);
        longint num;
        longint q;
        num = longint'(a) * (longint'(TARGET_RATE) - longint'(p))
            + longint'(b) * longint'(p) + longint'(TARGET_RATE) / 2;
        q = num / longint'(TARGET_RATE);
        if ((num % longint'(TARGET_RATE)) != 0 && num < 0)
            q = q - 1;
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic void resample_word(input t_in_word w);
        t_out_word   batch [MAX_RESULTS];
        int          n;
        int          cur;
        int unsigned step;
        int unsigned ph;
        n    = 0;
        cur  = int'(w.sample_in);
        step = 32'(rate_reg);
        if (rate_reg < RATE_MIN)
            step = 32'(RATE_MIN);
        if (rate_reg > RATE_MAX)
            step = 32'(RATE_MAX);
        ph = phase_acc;
        if (have_prev) begin
            while (ph < TARGET_RATE) begin
                if (n < MAX_RESULTS) begin
                    batch[n].sample_out = blend(prev_sample, cur, ph);
                    batch[n].run_last   = 1'b0;
                    n++;
                end
                ph += step;
            end
            ph -= TARGET_RATE;
        end
        if (w.stream_last) begin
            // tail positions past the final sample repeat it
            while (ph < TARGET_RATE) begin
                if (n < MAX_RESULTS) begin
                    batch[n].sample_out = w.sample_in;
                    batch[n].run_last   = 1'b0;
                    n++;
                end
                ph += step;
            end
            prev_sample = 0;
            phase_acc   = 0;
            have_prev   = 1'b0;
        end else begin
            prev_sample = cur;
            phase_acc   = ph;
            have_prev   = 1'b1;
        end
        if (n > 0)
            batch[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            sample_q = {sample_q, batch[i]};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_reg    = RATE_RESET;
            prev_sample = 0;
            phase_acc   = 0;
            have_prev   = 1'b0;
            words_seen  = 0;
            o_fails     = 0;
            sample_q.delete();
        end else begin
            // compare before predicting: a word accepted now cannot answer itself
            if (i_out_valid && !i_out_stall) begin
                if (sample_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", i_out_data));
                end else begin
                    oldest = sample_q.pop_front();
                    if (i_out_data.sample_out !== oldest.sample_out)
                        report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                                  i_out_data.sample_out, oldest.sample_out));
                    if (i_out_data.run_last !== oldest.run_last)
                        report_mismatch($sformatf("run_last %b, predicted %b",
                                                  i_out_data.run_last, oldest.run_last));
                end
                words_seen++;
            end
            if (i_in_valid && !i_in_stall)
                resample_word(i_in_data);
            if (psel && penable && pwrite && pready
                    && paddr[PADDR_W-1:2] == REG_SOURCE_RATE)
                rate_reg = pwdata[RATE_W-1:0];
        end
        o_pending = sample_q.size();
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Top of the resampler bench: clock, reset, stimulus and the final verdict.
// Depends on lir_pkg, linear_interp_resampler_core and lir_stream_checker.
module testbench;
    import lir_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 13;
    localparam int DRAIN_LIMIT = 50000;
    localparam int SETTLE      = 100;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    t_in_word            in_word   = '0;
    logic                in_stall;
    logic                out_valid;
    t_out_word           out_word;
    logic                out_stall = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [PDATA_W-1:0]  pwdata    = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int                  pending;
    int                  fails;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;

    linear_interp_resampler_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_word),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lir_stream_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .o_pending   (pending),
        .o_fails     (fails)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: stall at random, redrawn every cycle at the current rate.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Pick who idles: sender light / receiver heavy, the reverse, or nobody.
    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 22;
                recv_idle_pct = 85;
            end
            1: begin
                send_idle_pct = 85;
                recv_idle_pct = 22;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one input word; return right after the edge that accepts it.
    // Stall is sampled at the falling edge so it is settled for the next rise.
    task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{sample_in: smp, stream_last: lst};
        do @(negedge clk); while (in_stall);
        @(posedge clk);
    endtask

    // Drop valid, wait until every predicted word has come out, then let the
    // sequencer finish committing before anything touches the register.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (40) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, hold until pready.
    task automatic write_rate(input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_SOURCE_RATE) << 2;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One stream of random content; style 0 is full range, 1 is rail and near-zero values only,
    // 2 is a slow walk that looks like real audio. The final word is flagged last.
    task automatic send_stream(input int len, input int style);
        int walk;
        int smp;
        walk = int'($urandom_range(0, 65535)) - 32768;
        for (int i = 0; i < len; i++) begin
            case (style)
                0: smp = int'($urandom_range(0, 65535)) - 32768;
                1: begin
                    case ($urandom_range(3))
                        0: smp = -32768;
                        1: smp = 32767;
                        2: smp = 0;
                        default: smp = -1;
                    endcase
                end
                default: begin
                    walk = walk + int'($urandom_range(0, 4000)) - 2000;
                    if (walk > 32767)
                        walk = 32767;
                    if (walk < -32768)
                        walk = -32768;
                    smp = walk;
                end
            endcase
            send_word(smp[SAMPLE_W-1:0], i == len - 1);
        end
    endtask

    initial begin
        int unsigned rate_plan [PHASES];
        int          sent;
        int          len;
        int          waited;
        bit          leftover;

        rate_plan = '{16000, 44100, 0, 0, 8000, 262143, 1000, 999, 192001, 48000};
        // one phase at an arbitrary legal rate
        rate_plan[3] = $urandom_range(1000, 192000);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting at the reset rate of 48000.
        set_idling(0);
        send_word(16'sh7fff, 1'b1);          // single-sample stream
        send_word(-16'sd32768, 1'b0);        // full-scale swings
        send_word(16'sh7fff, 1'b0);
        send_word(-16'sd32768, 1'b0);
        send_word(16'sh7fff, 1'b1);
        send_word(16'sd0, 1'b0);             // first word alone gives nothing
        send_word(16'sd0, 1'b1);
        wait_idle();

        // Lowest rate: 16 interpolated plus 16 tail words on the last item.
        write_rate(1000);
        send_word(16'sh7fff, 1'b0);
        send_word(-16'sd32768, 1'b0);
        send_word(16'sd1, 1'b1);
        send_word(-16'sd32768, 1'b1);
        wait_idle();

        // Highest rate: most input words yield nothing.
        write_rate(192000);
        send_word(-16'sd32768, 1'b0);
        send_word(16'sh7fff, 1'b0);
        send_word(-16'sd1, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(16'sh7fff, 1'b1);
        send_word(-16'sd1, 1'b1);
        wait_idle();

        // Random phases, each at its own rate; out-of-range rates test the clamp.
        for (int ph = 0; ph < PHASES; ph++) begin
            set_idling(ph < 4 ? 0 : (ph < 7 ? 1 : 2));
            write_rate(rate_plan[ph]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // mostly proper streams, now and then a lone last-flagged word
                len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 10);
                send_stream(len, $urandom_range(2));
                sent += len;
            end
            wait_idle();
        end

        // Drain with a bound; anything still predicted then is a failure.
        in_valid <= 1'b0;
        waited = 0;
        do begin
            @(negedge clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
        leftover = (pending != 0);
        if (leftover)
            $display("[%0t] %0d predicted words never arrived", $realtime, pending);
        // catch any stray word that trails the last one
        repeat (SETTLE) @(posedge clk);

        if (fails == 0 && !leftover) begin
            $display("** linear_interp_resampler_core: PASSED **");
        end else begin
            $display("** linear_interp_resampler_core: FAILED **");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("[%0t] run timed out", $realtime);
        $display("** linear_interp_resampler_core: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/lir_pkg.sv
hw/rtl/lir_ctrl.sv
hw/rtl/lir_dpath.sv
hw/rtl/linear_interp_resampler_core.sv
hw/rtl/lir_checker.sv
bench/lir_stream_checker.sv
bench/testbench.sv
